@@ src/box_blur_3x3_edge_aware_defines.svh @@
// Assertion macros shared by the box blur RTL.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the clock cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bb3_pkg.sv @@
// Types, constants and helper functions of the 3x3 box blur.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned WIDTH_CFG_W  = 11;
  localparam int unsigned HEIGHT_CFG_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Item modes.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Datapath sizes.
  localparam int unsigned CH_W        = 8;
  localparam int unsigned LANES       = 3;
  localparam int unsigned WIN         = 3;
  localparam int unsigned CELLS       = WIN * WIN;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned NUM_W       = SUM_W + 1;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned LANE_LAT    = 2;

  // Result queue.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_last;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One averaging job: bit i of rmask / cmask marks window row / column i as inside the frame.
  typedef struct packed {
    logic           valid;
    logic           last;
    logic [WIN-1:0] rmask;
    logic [WIN-1:0] cmask;
  } job_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             sel;
    logic [COL_W-1:0] addr;
    pix_t             wdata;
  } line_req_t;

  function automatic logic [CNT_W-1:0] cell_count(logic [WIN-1:0] rm, logic [WIN-1:0] cm);
    logic [1:0] nr;
    logic [1:0] nc;
    nr = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
    nc = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
    return CNT_W'(nr) * CNT_W'(nc);
  endfunction

  // ceil(2^18 / (2*cnt)); exact floor division for every numerator the lanes produce.
  function automatic logic [RECIP_W-1:0] cell_recip(logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ src/bb3_lines.sv @@
// Two line stores, one bank per row parity, with registered read data.
module bb3_lines
  import bb3_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  line_req_t req_i,
  output pix_t      top_o,
  output pix_t      mid_o
);

  pix_t bank0 [MAX_WIDTH];
  pix_t bank1 [MAX_WIDTH];
  pix_t rd0_q;
  pix_t rd1_q;
  logic sel_q;

  // Read and write share the address; a read returns the entry before the write.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd0_q <= bank0[req_i.addr];
      rd1_q <= bank1[req_i.addr];
    end
    if (req_i.wr_en && !req_i.sel) begin
      bank0[req_i.addr] <= req_i.wdata;
    end
    if (req_i.wr_en && req_i.sel) begin
      bank1[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (req_i.rd_en) begin
      sel_q <= req_i.sel;
    end
  end

  assign top_o = sel_q ? rd1_q : rd0_q;
  assign mid_o = sel_q ? rd0_q : rd1_q;

endmodule

@@ src/bb3_lane.sv @@
// One color lane: masked 3x3 sum, then rounded mean by reciprocal multiply.
module bb3_lane
  import bb3_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  job_t                       job_i,
  input  logic [CELLS-1:0][CH_W-1:0] cells_i,
  output logic [CH_W-1:0]            mean_o
);

  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;
  logic [NUM_W-1:0]  num_d;
  logic [NUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              valid_q;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        if (job_i.rmask[i] && job_i.cmask[j]) begin
          sum = sum + SUM_W'(cells_i[i*WIN+j]);
        end
      end
    end
    cnt   = cell_count(job_i.rmask, job_i.cmask);
    // Rounding half up: (2*sum + cnt) / (2*cnt).
    num_d = {sum, 1'b0} + NUM_W'(cnt);
  end

  assign prod_d = PROD_W'(num_q) * PROD_W'(cell_recip(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= job_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      num_q <= num_d;
      cnt_q <= cnt;
    end
    if (valid_q) begin
      prod_q <= prod_d;
    end
  end

  assign mean_o = prod_q[RECIP_SHIFT +: CH_W];

endmodule

@@ src/bb3_merge.sv @@
// Joins the lane results with the frame-end flag and queues them for the output.
module bb3_merge
  import bb3_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  job_t                       job_i,
  input  logic [LANES-1:0][CH_W-1:0] mean_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output out_t                       out_data_o,
  output logic                       pop_o
);

  `include "box_blur_3x3_edge_aware_defines.svh"

  logic [LANE_LAT-1:0]   vld_q;
  logic [LANE_LAT-1:0]   last_q;
  logic                  push;
  logic                  pop;
  out_t                  entry;
  out_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  // The flags travel alongside the lane pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
    end else begin
      vld_q  <= {vld_q[LANE_LAT-2:0], job_i.valid};
      last_q <= {last_q[LANE_LAT-2:0], job_i.last};
    end
  end

  assign push = vld_q[LANE_LAT-1];
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    entry.out_red    = mean_i[0];
    entry.out_green  = mean_i[1];
    entry.out_blue   = mean_i[2];
    entry.frame_last = last_q[LANE_LAT-1];
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop_o       = pop;

  `BB3_ASSERT(a_queue_no_overflow, !push || pop || count_q != FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")

endmodule

@@ src/box_blur_3x3_edge_aware.sv @@
// Top level of the edge-aware 3x3 box blur.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes raster-order RGB pixels
// (mode 0) and, once the whole frame is in, flush items (mode 1) that drain the last
// row one output each. Pixels during a drain and flushes outside one are dropped.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries the rounded means;
// frame_last marks the final output. Config writes (cfg_valid_i, cfg_ready_o always
// high) set frame width and height and restart the frame.
// Sequencing: a pixel passes ST_PIX, then ST_JOB_A and/or ST_JOB_B, one per result
// it yields; a flush passes ST_DRD, which the first flush of a drain repeats for
// its second column, and then ST_JOB_D. Each line-store bank has one read port, so
// the first flush fetches its two columns on successive cycles. A job passes the
// lane registers num_q and prod_q and the merge queue before its result is output.
// When the receiver stalls, up to four results wait in the output queue; after that
// the sequencer holds and in_stall_o stays high until a transfer frees a slot.
// Reset selects 1024x4096 and clears position and queue; the line store is not
// cleared, as entries read before the frame writes them are masked out of the means.
module box_blur_3x3_edge_aware
  import bb3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "box_blur_3x3_edge_aware_defines.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PIX   = 3'd1;
  localparam logic [2:0] ST_JOB_A = 3'd2;
  localparam logic [2:0] ST_JOB_B = 3'd3;
  localparam logic [2:0] ST_DRD   = 3'd4;
  localparam logic [2:0] ST_JOB_D = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [COL_W-1:0]       w_last_q, w_last_d;
  logic [ROW_W-1:0]       h_last_q, h_last_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [COL_W-1:0]       drain_q, drain_d;
  logic                   done_q, done_d;
  logic                   need_a_q, need_a_d;
  logic                   need_b_q, need_b_d;
  logic                   top_ok_q, top_ok_d;
  logic                   col1_q, col1_d;
  logic                   col2_q, col2_d;
  logic                   pre_q, pre_d;
  pix_t                   px_q, px_d;
  logic [FIFO_CNT_W-1:0]  credit_q, credit_d;
  pix_t [WIN-1:0][WIN-1:0] window_q, window_d;

  logic                   in_acc;
  logic                   cfg_we;
  logic                   credit_ok;
  logic                   pop;
  logic                   last_px_acc;
  line_req_t              line_req;
  job_t                   job;
  pix_t                   line_top;
  pix_t                   line_mid;
  logic                   shift_en;
  pix_t                   new_bot;
  logic [WIDTH_CFG_W-1:0]  wv, wv_m1;
  logic [HEIGHT_CFG_W-1:0] hv, hv_m1;
  logic [LANES-1:0][CH_W-1:0] mean;

  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign credit_ok   = (credit_q != '0);

  assign wv    = cfg_data_i[WIDTH_CFG_W-1:0];
  assign wv_m1 = wv - WIDTH_CFG_W'(1);
  assign hv    = cfg_data_i[HEIGHT_CFG_W-1:0];
  assign hv_m1 = hv - HEIGHT_CFG_W'(1);

  always_comb begin
    state_d  = state_q;
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    col_d    = col_q;
    row_d    = row_q;
    drain_d  = drain_q;
    done_d   = done_q;
    need_a_d = need_a_q;
    need_b_d = need_b_q;
    top_ok_d = top_ok_q;
    col1_d   = col1_q;
    col2_d   = col2_q;
    pre_d    = pre_q;
    px_d     = px_q;
    line_req = '0;
    job      = '0;
    shift_en = 1'b0;
    new_bot  = line_mid;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.mode == MODE_PIXEL && !done_q) begin
          line_req.rd_en       = 1'b1;
          line_req.wr_en       = 1'b1;
          line_req.addr        = col_q;
          line_req.sel         = row_q[0];
          line_req.wdata.red   = in_data_i.in_red;
          line_req.wdata.green = in_data_i.in_green;
          line_req.wdata.blue  = in_data_i.in_blue;
          px_d     = line_req.wdata;
          need_a_d = (row_q != '0) && (col_q != '0);
          need_b_d = (row_q != '0) && (col_q == w_last_q);
          top_ok_d = (row_q > ROW_W'(1));
          col1_d   = (col_q != '0);
          col2_d   = (col_q > COL_W'(1));
          if (col_q == w_last_q) begin
            col_d = '0;
            if (row_q == h_last_q) begin
              done_d  = 1'b1;
              drain_d = '0;
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end else begin
            col_d = col_q + COL_W'(1);
          end
          state_d = ST_PIX;
        end else if (in_acc && in_data_i.mode == MODE_FLUSH && done_q) begin
          // The first flush loads two columns; later ones slide in one.
          line_req.rd_en = 1'b1;
          line_req.sel   = ~h_last_q[0];
          line_req.addr  = (drain_q == '0) ? '0 : drain_q + COL_W'(1);
          pre_d          = (drain_q == '0);
          state_d        = ST_DRD;
        end
      end
      ST_PIX: begin
        shift_en = 1'b1;
        new_bot  = px_q;
        if (need_a_q) begin
          state_d = ST_JOB_A;
        end else if (need_b_q) begin
          state_d = ST_JOB_B;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_JOB_A: begin
        if (credit_ok) begin
          job.valid = 1'b1;
          job.rmask = {1'b1, 1'b1, top_ok_q};
          job.cmask = {1'b1, 1'b1, col2_q};
          state_d   = need_b_q ? ST_JOB_B : ST_IDLE;
        end
      end
      ST_JOB_B: begin
        // Row end: the right-hand column lies outside the frame.
        if (credit_ok) begin
          job.valid = 1'b1;
          job.rmask = {1'b1, 1'b1, top_ok_q};
          job.cmask = {1'b1, col1_q, 1'b0};
          state_d   = ST_IDLE;
        end
      end
      ST_DRD: begin
        shift_en = 1'b1;
        if (pre_q) begin
          line_req.rd_en = 1'b1;
          line_req.sel   = ~h_last_q[0];
          line_req.addr  = COL_W'(1);
          pre_d          = 1'b0;
        end else begin
          state_d = ST_JOB_D;
        end
      end
      ST_JOB_D: begin
        if (credit_ok) begin
          job.valid = 1'b1;
          job.last  = (drain_q == w_last_q);
          job.rmask = {1'b0, 1'b1, (h_last_q != '0)};
          job.cmask = {(drain_q != w_last_q), 1'b1, (drain_q != '0)};
          if (drain_q == w_last_q) begin
            col_d   = '0;
            row_d   = '0;
            drain_d = '0;
            done_d  = 1'b0;
          end else begin
            drain_d = drain_q + COL_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A frame width or height write restarts the frame; out-of-range sizes are clamped.
    if (cfg_we && (cfg_index_i inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT})) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
      done_d  = 1'b0;
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        if (wv == '0) begin
          w_last_d = '0;
        end else if (wv > WIDTH_CFG_W'(MAX_WIDTH)) begin
          w_last_d = COL_W'(MAX_WIDTH - 1);
        end else begin
          w_last_d = wv_m1[COL_W-1:0];
        end
      end else begin
        if (hv == '0) begin
          h_last_d = '0;
        end else if (hv > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
          h_last_d = ROW_W'(MAX_HEIGHT - 1);
        end else begin
          h_last_d = hv_m1[ROW_W-1:0];
        end
      end
    end
  end

  always_comb begin
    window_d = window_q;
    if (shift_en) begin
      for (int r = 0; r < WIN; r++) begin
        window_d[r][0] = window_q[r][1];
        window_d[r][1] = window_q[r][2];
      end
      window_d[0][2] = line_top;
      window_d[1][2] = line_mid;
      window_d[2][2] = new_bot;
    end
  end

  assign credit_d = credit_q - FIFO_CNT_W'(job.valid) + FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      w_last_q <= COL_W'(MAX_WIDTH - 1);
      h_last_q <= ROW_W'(MAX_HEIGHT - 1);
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= '0;
      done_q   <= 1'b0;
      need_a_q <= 1'b0;
      need_b_q <= 1'b0;
      pre_q    <= 1'b0;
      credit_q <= FIFO_CNT_W'(FIFO_DEPTH);
    end else begin
      state_q  <= state_d;
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      col_q    <= col_d;
      row_q    <= row_d;
      drain_q  <= drain_d;
      done_q   <= done_d;
      need_a_q <= need_a_d;
      need_b_q <= need_b_d;
      pre_q    <= pre_d;
      credit_q <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_ok_q <= top_ok_d;
    col1_q   <= col1_d;
    col2_q   <= col2_d;
    px_q     <= px_d;
    window_q <= window_d;
  end

  bb3_lines u_lines (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (line_req),
    .top_o  (line_top),
    .mid_o  (line_mid)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [CELLS-1:0][CH_W-1:0] cells;

    always_comb begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          cells[i*WIN+j] = window_q[i][j][(LANES-1-k)*CH_W +: CH_W];
        end
      end
    end

    bb3_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .job_i   (job),
      .cells_i (cells),
      .mean_o  (mean[k])
    );
  end

  bb3_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .mean_i      (mean),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .pop_o       (pop)
  );

  // The final pixel of the frame is taken with no register write beside it.
  assign last_px_acc = in_acc && in_data_i.mode == MODE_PIXEL && !done_q &&
                       col_q == w_last_q && row_q == h_last_q && !cfg_we;

  `BB3_ASSERT(a_credit_bound, credit_q <= FIFO_CNT_W'(FIFO_DEPTH), "result credit above queue depth")
  `BB3_ASSERT(a_done_position, !done_q || (col_q == '0 && row_q == h_last_q), "bad drain position")
  `BB3_ASSERT_NEXT(a_last_pixel_done, last_px_acc, done_q, "last pixel did not start drain")

endmodule

@@ sim/tb_box_blur_3x3_edge_aware.sv @@
// Self-checking testbench of the edge-aware 3x3 box blur with its own blur predictor.
module tb_box_blur_3x3_edge_aware;
  import bb3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  box_blur_3x3_edge_aware uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: registers, two line buffers, the 3x3 window and the raster position.
  logic [WIDTH_CFG_W-1:0]  width_reg = WIDTH_CFG_W'(MAX_WIDTH);
  logic [HEIGHT_CFG_W-1:0] height_reg = HEIGHT_CFG_W'(MAX_HEIGHT);
  pix_t                    line_mem [2*MAX_WIDTH];
  pix_t [8:0]              blur_win = '0;
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;
  int unsigned             drain_pos = 0;
  bit                      draining = 1'b0;

  in_t         pixel_feed [$];
  out_t        blur_expect [$];
  int unsigned mismatches = 0;
  int unsigned pixel_xfers = 0;
  int unsigned flush_xfers = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    draining = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val[WIDTH_CFG_W-1:0];
      restart_frame();
    end else if (idx == CFG_FRAME_HEIGHT) begin
      height_reg = val[HEIGHT_CFG_W-1:0];
      restart_frame();
    end
  endfunction

  // Rounded-half-up mean over the cells whose row bit and column bit are both set.
  function automatic out_t blur_mean(input pix_t [8:0] cells, input logic [2:0] rmask,
                                     input logic [2:0] cmask, input logic last);
    int unsigned sr, sg, sb, cnt, i, j;
    out_t res;
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        if (rmask[i] && cmask[j]) begin
          sr += cells[3*i+j].red;
          sg += cells[3*i+j].green;
          sb += cells[3*i+j].blue;
          cnt++;
        end
      end
    end
    res.out_red    = 8'((2*sr + cnt) / (2*cnt));
    res.out_green  = 8'((2*sg + cnt) / (2*cnt));
    res.out_blue   = 8'((2*sb + cnt) / (2*cnt));
    res.frame_last = last;
    return res;
  endfunction

  function automatic void predict_blur(input in_t it);
    int unsigned w, h, cur, prv, i, j, c;
    pix_t px, top, mid;
    pix_t [8:0] cells;
    logic [2:0] rm, cm;
    logic last;
    w = frame_w();
    h = frame_h();
    cells = '0;
    cm = '0;
    if (it.mode == MODE_PIXEL) begin
      if (draining || col_pos >= w || row_pos >= h) return;
      px = {it.in_red, it.in_green, it.in_blue};
      // Row r-2 shares its buffer with row r, so the old entry is read before the write.
      cur = (row_pos % 2) * MAX_WIDTH + col_pos;
      prv = ((row_pos + 1) % 2) * MAX_WIDTH + col_pos;
      top = (row_pos >= 2) ? line_mem[cur] : '0;
      mid = (row_pos >= 1) ? line_mem[prv] : '0;
      line_mem[cur] = px;
      for (i = 0; i < 3; i++) begin
        blur_win[3*i]   = blur_win[3*i+1];
        blur_win[3*i+1] = blur_win[3*i+2];
      end
      blur_win[2] = top;
      blur_win[5] = mid;
      blur_win[8] = px;
      if (row_pos >= 1) begin
        rm = {2'b11, row_pos >= 2};
        if (col_pos >= 1)
          blur_expect.push_back(blur_mean(blur_win, rm, {2'b11, col_pos >= 2}, 1'b0));
        if (col_pos == w - 1) begin
          // The last column of the row above leaves too, its right neighbors outside.
          for (i = 0; i < 3; i++) begin
            cells[3*i]   = blur_win[3*i+1];
            cells[3*i+1] = blur_win[3*i+2];
          end
          blur_expect.push_back(blur_mean(cells, rm, {2'b01, col_pos >= 1}, 1'b0));
        end
      end
      if (col_pos + 1 < w) begin
        col_pos++;
      end else begin
        col_pos = 0;
        if (row_pos + 1 < h) begin
          row_pos++;
        end else begin
          draining = 1'b1;
          drain_pos = 0;
        end
      end
    end else begin
      if (!draining || drain_pos >= w) return;
      for (j = 0; j < 3; j++) begin
        if (drain_pos + j >= 1 && drain_pos + j - 1 < w) begin
          c = drain_pos + j - 1;
          cm[j] = 1'b1;
          cells[j] = (h >= 2) ? line_mem[(h % 2) * MAX_WIDTH + c] : '0;
          cells[3+j] = line_mem[((h - 1) % 2) * MAX_WIDTH + c];
        end
      end
      last = (drain_pos + 1 == w);
      blur_expect.push_back(blur_mean(cells, {2'b01, h >= 2}, cm, last));
      drain_pos++;
      if (last) restart_frame();
    end
  endfunction

  // Idle length: mostly short, a few long, with occasional stretches of none at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll == 0) calm = $urandom_range(20, 80);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic in_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
    in_t it;
    it.mode = MODE_PIXEL;
    it.in_red = r;
    it.in_green = g;
    it.in_blue = b;
    return it;
  endfunction

  function automatic logic [7:0] rand_channel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic in_t rand_pixel();
    return mk_pixel(rand_channel(), rand_channel(), rand_channel());
  endfunction

  function automatic in_t rand_flush();
    in_t it;
    it = in_t'($urandom);
    it.mode = MODE_FLUSH;
    return it;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: one item per transfer, with random idle cycles after each one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_blur(in_data_i);
        if (in_data_i.mode == MODE_PIXEL) pixel_xfers++;
        else flush_xfers++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          in_data_i <= pixel_feed.pop_front();
          in_valid_i <= 1'b1;
          gap_left = pick_gap(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each transfer with the oldest predicted blur result.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (blur_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = blur_expect.pop_front();
          check_field("out_red", out_data_o.out_red, want.out_red);
          check_field("out_green", out_data_o.out_green, want.out_green);
          check_field("out_blue", out_data_o.out_blue, want.out_blue);
          check_field("frame_last", 8'(out_data_o.frame_last), 8'(want.frame_last));
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  // Waits until every queued item has gone in and every result has come out,
  // then lets the sequencer finish any item that produced nothing.
  task automatic settle();
    while (pixel_feed.size() != 0 || in_valid_i || blur_expect.size() != 0)
      @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  // One well-formed frame; when noisy, ignored items are mixed in and the
  // sender may pause mid-frame until all results are back.
  task automatic queue_frame(input bit noisy, inout int unsigned useful);
    int unsigned w, h, total, cut, k;
    w = frame_w();
    h = frame_h();
    total = w * h;
    cut = (noisy && $urandom_range(0, 7) == 0) ? $urandom_range(1, total) : 0;
    for (k = 0; k < total; k++) begin
      if (k == cut && cut != 0) settle();
      if (noisy && $urandom_range(0, 19) == 0) pixel_feed.push_back(rand_flush());
      pixel_feed.push_back(rand_pixel());
      useful++;
    end
    for (k = 0; k < w; k++) begin
      if (noisy && $urandom_range(0, 19) == 0) pixel_feed.push_back(rand_pixel());
      pixel_feed.push_back(rand_flush());
      useful++;
    end
    if (noisy && $urandom_range(0, 9) == 0) pixel_feed.push_back(rand_flush());
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_width_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return {2'($urandom), 11'd0};
    if (roll < 12) return 13'd1;
    if (roll < 22) return 13'($urandom_range(9, 40));
    if (roll < 28) return {2'($urandom), 11'($urandom_range(2, 8))};
    return 13'($urandom_range(2, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 13'd0;
    if (roll < 14) return 13'd1;
    if (roll < 20) return 13'($urandom_range(7, 12));
    return 13'($urandom_range(2, 6));
  endfunction

  initial begin
    int unsigned useful, k, n;
    useful = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size is 1024x4096: a few pixels of row 0 give nothing, nor does an early flush.
    pixel_feed.push_back(mk_pixel(8'd0, 8'd0, 8'd0));
    pixel_feed.push_back(mk_pixel(8'd255, 8'd255, 8'd255));
    pixel_feed.push_back(mk_pixel(8'd170, 8'd85, 8'd1));
    pixel_feed.push_back(mk_pixel(8'd85, 8'd170, 8'd254));
    pixel_feed.push_back(rand_flush());
    settle();

    // 3x3 frame: corners, edges and the center, with extreme channel values.
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    pixel_feed.push_back(mk_pixel(8'd255, 8'd255, 8'd255));
    pixel_feed.push_back(mk_pixel(8'd0, 8'd0, 8'd0));
    pixel_feed.push_back(mk_pixel(8'd255, 8'd0, 8'd128));
    pixel_feed.push_back(mk_pixel(8'd1, 8'd2, 8'd3));
    pixel_feed.push_back(mk_pixel(8'd254, 8'd253, 8'd252));
    settle();
    // Registers beyond the second are no-ops and must not restart the frame.
    write_reg(CFG_IDX_W'(2), 13'h1fff);
    write_reg(CFG_IDX_W'(3), 13'h0aaa);
    pixel_feed.push_back(mk_pixel(8'd0, 8'd255, 8'd0));
    pixel_feed.push_back(mk_pixel(8'd128, 8'd127, 8'd129));
    pixel_feed.push_back(mk_pixel(8'd255, 8'd255, 8'd255));
    pixel_feed.push_back(mk_pixel(8'd0, 8'd0, 8'd1));
    pixel_feed.push_back(mk_pixel(8'd9, 8'd9, 8'd9));
    for (k = 0; k < 4; k++) pixel_feed.push_back(rand_flush());
    settle();

    // Zero sizes count as one; width bits above the register are dropped.
    write_reg(CFG_FRAME_WIDTH, 13'h1800);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    pixel_feed.push_back(mk_pixel(8'd77, 8'd200, 8'd13));
    pixel_feed.push_back(rand_flush());
    pixel_feed.push_back(rand_flush());
    settle();

    // Oversized width clamps to a full 1024-pixel row; the frame is cut short.
    write_reg(CFG_FRAME_WIDTH, 13'd2047);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    for (k = 0; k < MAX_WIDTH; k++) pixel_feed.push_back(rand_pixel());
    for (k = 0; k < 3; k++) pixel_feed.push_back(rand_flush());
    settle();

    // Oversized height with a one-pixel column, aborted partway.
    write_reg(CFG_FRAME_HEIGHT, 13'h1fff);
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    for (k = 0; k < 40; k++) pixel_feed.push_back(rand_pixel());
    settle();

    while (useful < 850) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_FRAME_WIDTH, rand_width_code());
        write_reg(CFG_FRAME_HEIGHT, rand_height_code());
      end else begin
        write_reg(CFG_FRAME_HEIGHT, rand_height_code());
        write_reg(CFG_FRAME_WIDTH, rand_width_code());
      end
      if ($urandom_range(0, 9) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 3)), 13'($urandom));
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) queue_frame(1'b1, useful);
      // Sometimes leave a partial frame behind for the next register write to abandon.
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(0, frame_w() * frame_h() - 1);
        for (k = 0; k < n; k++) pixel_feed.push_back(rand_pixel());
      end
      settle();
    end

    settle();
    $display("Run covered %0d pixel and %0d flush transfers, %0d results checked,",
             pixel_xfers, flush_xfers, results_seen);
    $display("%0d register writes, frames from 1x1 up to clamped sizes, random idling.",
             reg_writes);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout: %0d results still expected", blur_expect.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/bb3_pkg.sv
src/bb3_lines.sv
src/bb3_lane.sv
src/bb3_merge.sv
src/box_blur_3x3_edge_aware.sv
sim/tb_box_blur_3x3_edge_aware.sv
